>>> src/oaid_pkg.sv
// ----------------------------------------------------------------------------
// oaid_pkg
// Types and codes shared by the ordered array insert/delete core.
// ----------------------------------------------------------------------------
package oaid_pkg;

  // Operation codes
  localparam logic [2:0] OP_INS_LAST  = 3'd0;
  localparam logic [2:0] OP_INS_FIRST = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_DEL_LAST  = 3'd3;
  localparam logic [2:0] OP_DEL_FIRST = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         position;
    logic signed [31:0] key_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         live_count;
    logic signed [31:0] read_value;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_INS,
    KIND_DEL,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    SRC_BELOW,
    SRC_ABOVE,
    SRC_AT
  } rd_src_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    cur_load_count;
    logic    cur_load_at;
    logic    cur_dec;
    logic    cur_inc;
    logic    rd_en;
    rd_src_t rd_src;
    logic    wr_shift;
    logic    wr_key;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    finish;
    logic    use_rdata;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  err;
    logic  ins_no_shift;
    logic  del_no_shift;
    logic  up_last;
    logic  dn_last;
  } sts_t;

endpackage

>>> src/oaid_datapath.sv
// ----------------------------------------------------------------------------
// oaid_datapath
// Entry memory, live count, shift cursor, request decode and result register.
// ----------------------------------------------------------------------------
module oaid_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  oaid_pkg::req_t request,
  input  oaid_pkg::cmd_t cmd,
  output oaid_pkg::sts_t sts,
  output logic           done,
  output oaid_pkg::rsp_t result
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;

  logic [2:0]         req_op;
  logic [5:0]         req_pos;
  logic signed [31:0] req_key;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] cursor;
  logic [CW-1:0] cur_m1;
  logic [CW-1:0] cur_p1;

  logic [CMPW-1:0] at;
  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] cursor_ext;
  logic [1:0]      err_code;
  oaid_pkg::kind_t kind;

  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               wen;

  assign count_ext  = CMPW'(count);
  assign cursor_ext = CMPW'(cursor);
  assign cur_m1     = cursor - CW'(1);
  assign cur_p1     = cursor + CW'(1);

  // Decode the held request: target index, kind and error
  always_comb begin
    at       = CMPW'(req_pos);
    kind     = oaid_pkg::KIND_NOP;
    err_code = oaid_pkg::ST_OK;
    case (req_op)
      oaid_pkg::OP_INS_LAST: begin
        at   = count_ext;
        kind = oaid_pkg::KIND_INS;
      end
      oaid_pkg::OP_INS_FIRST: begin
        at   = '0;
        kind = oaid_pkg::KIND_INS;
      end
      oaid_pkg::OP_INS_AT: begin
        kind = oaid_pkg::KIND_INS;
      end
      oaid_pkg::OP_DEL_LAST: begin
        at   = count_ext - CMPW'(1);
        kind = oaid_pkg::KIND_DEL;
      end
      oaid_pkg::OP_DEL_FIRST: begin
        at   = '0;
        kind = oaid_pkg::KIND_DEL;
      end
      oaid_pkg::OP_DEL_AT: begin
        kind = oaid_pkg::KIND_DEL;
      end
      oaid_pkg::OP_READ: begin
        kind = oaid_pkg::KIND_READ;
      end
      default: begin
        kind = oaid_pkg::KIND_NOP;
      end
    endcase

    case (kind)
      oaid_pkg::KIND_INS: begin
        // range test ahead of the full test
        if (at > count_ext) begin
          err_code = oaid_pkg::ST_RANGE;
        end else if (count_ext >= CMPW'(CAPACITY)) begin
          err_code = oaid_pkg::ST_FULL;
        end
      end
      oaid_pkg::KIND_DEL: begin
        if (count == '0) begin
          err_code = oaid_pkg::ST_UNDERFLOW;
        end else if (at >= count_ext) begin
          err_code = oaid_pkg::ST_RANGE;
        end
      end
      oaid_pkg::KIND_READ: begin
        if (at >= count_ext) begin
          err_code = oaid_pkg::ST_RANGE;
        end
      end
      default: begin
        err_code = oaid_pkg::ST_OK;
      end
    endcase
  end

  assign sts.kind         = kind;
  assign sts.err          = (err_code != oaid_pkg::ST_OK);
  assign sts.ins_no_shift = (at == count_ext);
  assign sts.del_no_shift = (at == count_ext - CMPW'(1));
  assign sts.up_last      = (cursor_ext - CMPW'(1) == at);
  assign sts.dn_last      = (cursor_ext + CMPW'(2) == count_ext);

  always_comb begin
    case (cmd.rd_src)
      oaid_pkg::SRC_BELOW: raddr = cur_m1[AW-1:0];
      oaid_pkg::SRC_ABOVE: raddr = cur_p1[AW-1:0];
      default:             raddr = at[AW-1:0];
    endcase
  end

  assign wen   = cmd.wr_shift | cmd.wr_key;
  assign waddr = cmd.wr_shift ? cursor[AW-1:0] : at[AW-1:0];
  assign wdata = cmd.wr_shift ? rdata : req_key;

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op  <= request.operation;
      req_pos <= request.position;
      req_key <= request.key_value;
    end
    if (cmd.cur_load_count) begin
      cursor <= count;
    end else if (cmd.cur_load_at) begin
      cursor <= at[CW-1:0];
    end else if (cmd.cur_dec) begin
      cursor <= cur_m1;
    end else if (cmd.cur_inc) begin
      cursor <= cur_p1;
    end
    if (cmd.finish) begin
      result.status     <= err_code;
      result.live_count <= 7'(count_next);
      result.read_value <= cmd.use_rdata ? rdata : 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= cmd.finish;
    end
  end

endmodule

>>> src/oaid_ctrl.sv
// ----------------------------------------------------------------------------
// oaid_ctrl
// Sequencer: checks the request, walks the shift one entry at a time, closes.
// ----------------------------------------------------------------------------
module oaid_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  oaid_pkg::sts_t sts,
  output oaid_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_DN_RD,
    S_DN_WR,
    S_RD_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_src = oaid_pkg::SRC_AT;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err || sts.kind == oaid_pkg::KIND_NOP) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          case (sts.kind)
            oaid_pkg::KIND_INS: begin
              if (sts.ins_no_shift) begin
                state_next = S_PUT;
              end else begin
                cmd.cur_load_count = 1'b1;
                state_next         = S_UP_RD;
              end
            end
            oaid_pkg::KIND_DEL: begin
              if (sts.del_no_shift) begin
                cmd.cnt_dec = 1'b1;
                cmd.finish  = 1'b1;
                state_next  = S_IDLE;
              end else begin
                cmd.cur_load_at = 1'b1;
                state_next      = S_DN_RD;
              end
            end
            default: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = oaid_pkg::SRC_AT;
              state_next = S_RD_WAIT;
            end
          endcase
        end
      end
      S_UP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = oaid_pkg::SRC_BELOW;
        state_next = S_UP_WR;
      end
      S_UP_WR: begin
        // move the neighbor below up into the cursor slot
        cmd.wr_shift = 1'b1;
        cmd.cur_dec  = 1'b1;
        state_next   = sts.up_last ? S_PUT : S_UP_RD;
      end
      S_PUT: begin
        cmd.wr_key  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.finish  = 1'b1;
        state_next  = S_IDLE;
      end
      S_DN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = oaid_pkg::SRC_ABOVE;
        state_next = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.cur_inc  = 1'b1;
        if (sts.dn_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.finish  = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_DN_RD;
        end
      end
      S_RD_WAIT: begin
        cmd.use_rdata = 1'b1;
        cmd.finish    = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/ordered_array_insert_delete_core.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_core
// Packed array of signed keys with insert/delete by shifting and indexed read.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start, accepted !busy  request (operation, position, key_value)
//  result    done, one cycle        result  (status, live_count, read_value)
//
//  After accept the request is checked; an error, a no-op or a delete then
//  closes, a read or an insert closes after its memory read or key write,
//  and every entry that shifts adds one memory read then one memory write.
//  Busy drops in the cycle of the done strobe, so the next start can be taken
//  there; start is ignored while busy is high.
//  Synchronous reset empties the array at once; no clearing pass is needed.
//  The receiver cannot stall: each result is valid for its strobe cycle only.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_core #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  oaid_pkg::req_t request,
  output logic           done,
  output oaid_pkg::rsp_t result
);

  oaid_pkg::cmd_t cmd;
  oaid_pkg::sts_t sts;

  oaid_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  oaid_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .done    (done),
    .result  (result)
  );

  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  a_start_takes : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result strobes back to back");

  a_underflow_empty : assert property (@(posedge clk) disable iff (rst)
    (done && result.status == oaid_pkg::ST_UNDERFLOW) |-> (result.live_count == 7'd0))
    else $error("underflow reported on a non-empty array");

  a_full_count : assert property (@(posedge clk) disable iff (rst)
    (done && result.status == oaid_pkg::ST_FULL) |-> (result.live_count == 7'(CAPACITY)))
    else $error("full reported below capacity");

endmodule
